/* rtl/tps_pkg.sv */
// tps_pkg: shared types and codes for the tone pattern sequencer
// no dependencies; imported by the control path and the step memory

package tps_pkg;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_PLAY = 2'd1,
        OP_STOP = 2'd2,
        OP_TICK = 2'd3
    } t_op;

    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] dur;
    } t_step;

    localparam logic [7:0] DUTY_RESET = 8'd128;

endpackage

/* rtl/tps_if.sv */
// tps_cmd_if and tps_rsp_if: valid/ready channels of the tone pattern sequencer
// no dependencies

interface tps_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic [7:0]  step_index;
    logic [15:0] step_freq;
    logic [15:0] step_dur;
    logic [7:0]  play_count;
    logic [7:0]  play_duty;

    modport source (output valid, op, now_ms, step_index, step_freq, step_dur,
                    play_count, play_duty, input ready);
    modport sink (input valid, op, now_ms, step_index, step_freq, step_dur,
                  play_count, play_duty, output ready);
endinterface

interface tps_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] tone_freq;
    logic [7:0]  tone_duty;
    logic        busy_res;
    logic        play_ok;
    logic [7:0]  current_step;

    modport source (output valid, tone_freq, tone_duty, busy_res, play_ok,
                    current_step, input ready);
    modport sink (input valid, tone_freq, tone_duty, busy_res, play_ok,
                  current_step, output ready);
endinterface

/* rtl/tps_step_mem.sv */
// tps_step_mem: step table, one write and one registered read port
// depends on tps_pkg; entries never written read as zero via per-entry valid bits

module tps_step_mem
    import tps_pkg::*;
#(
    parameter int MAX_STEPS = 256,
    parameter int AW        = $clog2(MAX_STEPS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_step         i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_step         o_rd_data
);

    t_step                r_mem [MAX_STEPS];
    logic [MAX_STEPS-1:0] r_vld;
    t_step                r_rd;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd : '0;

endmodule

/* rtl/tps_ctrl.sv */
// tps_ctrl: accept stage, step state update and result register
// depends on tps_pkg and tps_if; drives the step memory ports

module tps_ctrl
    import tps_pkg::*;
#(
    parameter int MAX_STEPS = 256,
    parameter int AW        = $clog2(MAX_STEPS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tps_cmd_if.sink       i_cmd,
    tps_rsp_if.source     o_rsp,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output t_step         o_wr_data,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  t_step         i_rd_data
);

    // accept stage
    logic        r_s1_valid;
    t_op         r_op;
    logic [31:0] r_now;
    logic [7:0]  r_count;
    logic [7:0]  r_duty;

    // step state
    logic [7:0]  r_pos,        n_pos;
    logic [7:0]  r_total,      n_total;
    logic [31:0] r_deadline,   n_deadline;
    logic        r_playing,    n_playing;
    logic [7:0]  r_duty_hold,  n_duty_hold;
    logic [15:0] r_drive_freq, n_drive_freq;
    logic [7:0]  r_drive_duty, n_drive_duty;
    logic        n_ok;

    // result register
    logic        r_out_valid;
    logic        r_ok;

    logic        w_in_acc;
    logic        w_s1_adv;
    logic [31:0] w_diff;
    logic [8:0]  w_next;
    logic [7:0]  w_pos_cur;
    logic [7:0]  w_pos_inc;

    assign w_s1_adv    = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_cmd.ready = !r_s1_valid || w_s1_adv;
    assign w_in_acc    = i_cmd.valid && i_cmd.ready;

    assign w_diff = r_now - r_deadline;
    assign w_next = {1'b0, r_pos} + 9'd1;

    always_comb begin
        n_pos        = r_pos;
        n_total      = r_total;
        n_deadline   = r_deadline;
        n_playing    = r_playing;
        n_duty_hold  = r_duty_hold;
        n_drive_freq = r_drive_freq;
        n_drive_duty = r_drive_duty;
        n_ok         = 1'b0;
        case (r_op)
            OP_PLAY: begin
                if (r_count != 8'd0) begin
                    n_total     = ({1'b0, r_count} > 9'(MAX_STEPS)) ? 8'(MAX_STEPS)
                                                                     : r_count;
                    n_pos       = 8'd0;
                    n_playing   = 1'b1;
                    n_duty_hold = r_duty;
                    n_deadline  = r_now + {16'd0, i_rd_data.dur};
                    n_ok        = 1'b1;
                    if (i_rd_data.freq == 16'd0) begin
                        n_drive_freq = 16'd0;
                        n_drive_duty = 8'd0;
                    end else begin
                        n_drive_freq = i_rd_data.freq;
                        n_drive_duty = r_duty;
                    end
                end
            end
            OP_STOP: begin
                n_pos        = 8'd0;
                n_total      = 8'd0;
                n_deadline   = 32'd0;
                n_playing    = 1'b0;
                n_drive_freq = 16'd0;
                n_drive_duty = 8'd0;
            end
            OP_TICK: begin
                if (r_playing && !w_diff[31]) begin
                    if (w_next >= {1'b0, r_total}) begin
                        n_pos        = 8'd0;
                        n_total      = 8'd0;
                        n_deadline   = 32'd0;
                        n_playing    = 1'b0;
                        n_drive_freq = 16'd0;
                        n_drive_duty = 8'd0;
                    end else begin
                        n_pos      = w_next[7:0];
                        n_deadline = r_now + {16'd0, i_rd_data.dur};
                        if (i_rd_data.freq == 16'd0) begin
                            n_drive_freq = 16'd0;
                            n_drive_duty = 8'd0;
                        end else begin
                            n_drive_freq = i_rd_data.freq;
                            n_drive_duty = r_duty_hold;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // forward the step position of the transaction leaving the accept stage
    assign w_pos_cur = w_s1_adv ? n_pos : r_pos;
    assign w_pos_inc = w_pos_cur + 8'd1;

    assign o_rd_en   = w_in_acc;
    assign o_rd_addr = (t_op'(i_cmd.op) == OP_PLAY) ? '0 : w_pos_inc[AW-1:0];
    assign o_wr_en   = w_in_acc && (t_op'(i_cmd.op) == OP_LOAD)
                       && ({1'b0, i_cmd.step_index} < 9'(MAX_STEPS));
    assign o_wr_addr = i_cmd.step_index[AW-1:0];
    assign o_wr_data = '{freq: i_cmd.step_freq, dur: i_cmd.step_dur};

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op    <= t_op'(i_cmd.op);
            r_now   <= i_cmd.now_ms;
            r_count <= i_cmd.play_count;
            r_duty  <= i_cmd.play_duty;
        end
        if (w_s1_adv) begin
            r_ok <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pos        <= 8'd0;
            r_total      <= 8'd0;
            r_deadline   <= 32'd0;
            r_playing    <= 1'b0;
            r_duty_hold  <= DUTY_RESET;
            r_drive_freq <= 16'd0;
            r_drive_duty <= 8'd0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid  <= 1'b1;
                r_pos        <= n_pos;
                r_total      <= n_total;
                r_deadline   <= n_deadline;
                r_playing    <= n_playing;
                r_duty_hold  <= n_duty_hold;
                r_drive_freq <= n_drive_freq;
                r_drive_duty <= n_drive_duty;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.tone_freq    = r_drive_freq;
    assign o_rsp.tone_duty    = r_drive_duty;
    assign o_rsp.busy_res     = r_playing;
    assign o_rsp.play_ok      = r_ok;
    assign o_rsp.current_step = r_pos;

`ifndef SYNTHESIS
    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> (r_total != 8'd0))
        else $error("playing with zero step count");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> (r_pos < r_total))
        else $error("step position beyond step count");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_playing |-> (r_drive_freq == 16'd0 && r_drive_duty == 8'd0 && r_pos == 8'd0))
        else $error("idle sequencer not silent");

    a_silent_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drive_freq == 16'd0) |-> (r_drive_duty == 8'd0))
        else $error("duty driven on a silent step");

    a_ok_only_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv && (r_op != OP_PLAY) |=> !r_ok)
        else $error("play_ok on a non-play transaction");
`endif

endmodule

/* rtl/tone_pattern_sequencer.sv */
// tone_pattern_sequencer: a command transaction passes the accept stage and the result register
// before result valid; throughput one transaction per cycle while the result side does not
// stall; the step memory read is issued at accept and its registered data is consumed from the
// accept stage, with the step position forwarded from the update stage; reset (synchronous,
// active low) clears state and all step valid bits together, so the table reads as zero at once; no clearing pass
// depends on tps_pkg, tps_if, tps_step_mem, tps_ctrl

module tone_pattern_sequencer
    import tps_pkg::*;
#(
    parameter int MAX_STEPS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tps_cmd_if.sink   i_cmd,
    tps_rsp_if.source o_rsp
);

    localparam int AW = $clog2(MAX_STEPS);

    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_step         w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_step         w_rd_data;

    tps_ctrl #(
        .MAX_STEPS (MAX_STEPS),
        .AW        (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_rsp     (o_rsp),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data)
    );

    tps_step_mem #(
        .MAX_STEPS (MAX_STEPS),
        .AW        (AW)
    ) u_step_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule

/* test/tb_tone_pattern_sequencer.sv */
// tb_tone_pattern_sequencer: self-checking testbench for the tone pattern sequencer
// a table of directed items is followed by random load, play, tick and stop sessions
// depends on tps_pkg, tps_if and the tone_pattern_sequencer rtl

module tb_tone_pattern_sequencer;
    import tps_pkg::*;

    localparam int STEP_SLOTS  = 256;
    localparam int STALL_LIMIT = 1000;
    localparam int ITEM_TARGET = 950;
    localparam int TAIL_START  = 850;

    typedef struct packed {
        t_op         op;
        logic [31:0] now_ms;
        logic [7:0]  step_index;
        logic [15:0] step_freq;
        logic [15:0] step_dur;
        logic [7:0]  play_count;
        logic [7:0]  play_duty;
    } t_tone_cmd;

    typedef struct packed {
        logic [15:0] tone_freq;
        logic [7:0]  tone_duty;
        logic        busy_res;
        logic        play_ok;
        logic [7:0]  current_step;
    } t_tone_result;

    typedef struct packed {
        t_tone_cmd    cmd;
        logic         fixed;
        t_tone_result res;
    } t_stim_row;

    localparam t_tone_result SILENT_IDLE = '0;

    logic i_clk;
    logic i_rst_n;

    tps_cmd_if cmd_if ();
    tps_rsp_if rsp_if ();

    tone_pattern_sequencer #(
        .MAX_STEPS(STEP_SLOTS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_rsp  (rsp_if)
    );

    logic [15:0] tbl_freq [STEP_SLOTS];
    logic [15:0] tbl_dur  [STEP_SLOTS];
    logic [8:0]  seq_pos;
    logic [8:0]  seq_total;
    logic [31:0] seq_deadline;
    logic        seq_playing;
    logic [7:0]  seq_duty;
    logic [15:0] drv_freq;
    logic [7:0]  drv_duty;

    t_tone_result pending_tones [$];
    t_stim_row    directed_rows [22];

    int          fail_count   = 0;
    int          useful_items = 0;
    int          quiet_cycles = 0;
    int          gap_odds     = 4;
    bit          tail_quiet   = 1'b0;
    logic [31:0] ms_clock;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void seq_reset();
        for (int i = 0; i < STEP_SLOTS; i++) begin
            tbl_freq[i] = '0;
            tbl_dur[i]  = '0;
        end
        seq_pos      = '0;
        seq_total    = '0;
        seq_deadline = '0;
        seq_playing  = 1'b0;
        seq_duty     = DUTY_RESET;
        drv_freq     = '0;
        drv_duty     = '0;
    endfunction

    function automatic void seq_halt();
        drv_freq     = '0;
        drv_duty     = '0;
        seq_playing  = 1'b0;
        seq_pos      = '0;
        seq_total    = '0;
        seq_deadline = '0;
    endfunction

    function automatic void drive_step(input logic [8:0] pos);
        logic [15:0] f;
        f = (pos < STEP_SLOTS) ? tbl_freq[pos[7:0]] : 16'd0;
        drv_freq = f;
        drv_duty = (f == 16'd0) ? 8'd0 : seq_duty;
    endfunction

    function automatic logic [31:0] step_len(input logic [8:0] pos);
        return (pos < STEP_SLOTS) ? {16'd0, tbl_dur[pos[7:0]]} : 32'd0;
    endfunction

    function automatic t_tone_result predict_tone(input t_tone_cmd c);
        t_tone_result r;
        logic [31:0]  lag;
        logic [8:0]   nxt;
        r.play_ok = 1'b0;
        case (c.op)
            OP_LOAD: begin
                tbl_freq[c.step_index] = c.step_freq;
                tbl_dur[c.step_index]  = c.step_dur;
            end
            OP_PLAY: begin
                if (c.play_count != 8'd0) begin
                    seq_total    = (c.play_count > STEP_SLOTS) ? 9'(STEP_SLOTS)
                                                               : {1'b0, c.play_count};
                    seq_pos      = '0;
                    seq_playing  = 1'b1;
                    seq_duty     = c.play_duty;
                    drive_step(9'd0);
                    seq_deadline = c.now_ms + step_len(9'd0);
                    r.play_ok    = 1'b1;
                end
            end
            OP_STOP: seq_halt();
            OP_TICK: begin
                lag = c.now_ms - seq_deadline;
                if (seq_playing && !lag[31]) begin
                    nxt = seq_pos + 9'd1;
                    if (nxt >= seq_total) begin
                        seq_halt();
                    end else begin
                        seq_pos = nxt;
                        drive_step(nxt);
                        seq_deadline = c.now_ms + step_len(nxt);
                    end
                end
            end
        endcase
        r.tone_freq    = drv_freq;
        r.tone_duty    = drv_duty;
        r.busy_res     = seq_playing;
        r.current_step = seq_pos[7:0];
        return r;
    endfunction

    function automatic t_tone_cmd rand_cmd(input t_op op);
        t_tone_cmd c;
        c.op         = op;
        c.now_ms     = $urandom;
        c.step_index = 8'($urandom);
        c.step_freq  = 16'($urandom);
        c.step_dur   = 16'($urandom);
        c.play_count = 8'($urandom);
        c.play_duty  = 8'($urandom);
        return c;
    endfunction

    task automatic idle_cycles(input int n);
        cmd_if.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (pending_tones.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_cmd(input t_tone_cmd c, input logic fixed, input t_tone_result fixed_res);
        t_tone_result r;
        if (!tail_quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
            idle_cycles($urandom_range(1, 13));
        if (c.op == OP_LOAD || c.op == OP_PLAY || seq_playing)
            useful_items++;
        cmd_if.valid      <= 1'b1;
        cmd_if.op         <= c.op;
        cmd_if.now_ms     <= c.now_ms;
        cmd_if.step_index <= c.step_index;
        cmd_if.step_freq  <= c.step_freq;
        cmd_if.step_dur   <= c.step_dur;
        cmd_if.play_count <= c.play_count;
        cmd_if.play_duty  <= c.play_duty;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        r = predict_tone(c);
        pending_tones.push_back(fixed ? fixed_res : r);
        @(negedge i_clk);
    endtask

    task automatic send_rand(input t_tone_cmd c);
        send_cmd(c, 1'b0, SILENT_IDLE);
    endtask

    task automatic run_session();
        int        n_steps;
        int        budget;
        int        pick;
        t_tone_cmd c;
        gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
        n_steps  = $urandom_range(1, 8);
        if ($urandom_range(0, 5) == 0)
            ms_clock = $urandom;
        for (int i = 0; i < n_steps; i++) begin
            c = rand_cmd(OP_LOAD);
            if ($urandom_range(0, 9) != 0)
                c.step_index = 8'(i);
            if ($urandom_range(0, 4) == 0)
                c.step_freq = 16'd0;
            if ($urandom_range(0, 15) != 0)
                c.step_dur = 16'($urandom_range(0, 4));
            send_rand(c);
        end
        c = rand_cmd(OP_PLAY);
        c.now_ms = ms_clock;
        if ($urandom_range(0, 7) != 0)
            c.play_count = 8'(n_steps);
        send_rand(c);
        budget = 6 * n_steps + 4;
        while (budget > 0 && seq_playing) begin
            budget--;
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                c = rand_cmd(t_op'($urandom_range(0, 3)));
            end else if (pick == 1) begin
                c = rand_cmd(OP_LOAD);
                c.step_index = 8'($urandom_range(0, 8));
                c.step_dur   = 16'($urandom_range(0, 4));
            end else if (pick == 2) begin
                c = rand_cmd(OP_PLAY);
                c.now_ms     = ms_clock;
                c.play_count = 8'($urandom_range(0, 8));
            end else if (pick == 3) begin
                c = rand_cmd(OP_STOP);
            end else begin
                ms_clock += 32'($urandom_range(0, 3));
                c = rand_cmd(OP_TICK);
                c.now_ms = ms_clock;
            end
            send_rand(c);
        end
        if (seq_playing && $urandom_range(0, 1) == 0)
            send_rand(rand_cmd(OP_STOP));
    endtask

    initial begin
        int run_len;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready <= 1'b1;
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 25);
            repeat (run_len) @(negedge i_clk);
            if (!tail_quiet) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_tone_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_tones.size() == 0) begin
                $error("unexpected result transaction");
                fail_count++;
            end else begin
                want = pending_tones.pop_front();
                if (rsp_if.tone_freq !== want.tone_freq) begin
                    $error("tone_freq: expected %0d, actual %0d",
                           want.tone_freq, rsp_if.tone_freq);
                    fail_count++;
                end
                if (rsp_if.tone_duty !== want.tone_duty) begin
                    $error("tone_duty: expected %0d, actual %0d",
                           want.tone_duty, rsp_if.tone_duty);
                    fail_count++;
                end
                if (rsp_if.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0d, actual %0d",
                           want.busy_res, rsp_if.busy_res);
                    fail_count++;
                end
                if (rsp_if.play_ok !== want.play_ok) begin
                    $error("play_ok: expected %0d, actual %0d",
                           want.play_ok, rsp_if.play_ok);
                    fail_count++;
                end
                if (rsp_if.current_step !== want.current_step) begin
                    $error("current_step: expected %0d, actual %0d",
                           want.current_step, rsp_if.current_step);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL tone_pattern_sequencer");
            $finish;
        end
    end

    initial begin
        bit mid_drain_done;
        mid_drain_done    = 1'b0;
        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.op         = OP_LOAD;
        cmd_if.now_ms     = '0;
        cmd_if.step_index = '0;
        cmd_if.step_freq  = '0;
        cmd_if.step_dur   = '0;
        cmd_if.play_count = '0;
        cmd_if.play_duty  = '0;
        ms_clock          = '0;
        seq_reset();

        directed_rows = '{
            '{'{OP_TICK, 32'd0, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0}, 1'b1, SILENT_IDLE},
            '{'{OP_STOP, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF},
              1'b1, SILENT_IDLE},
            '{'{OP_PLAY, 32'd5, 8'd0, 16'd0, 16'd0, 8'd0, 8'hFF}, 1'b1, SILENT_IDLE},
            '{'{OP_PLAY, 32'd100, 8'd0, 16'd0, 16'd0, 8'd1, 8'hAA}, 1'b1,
              '{16'd0, 8'd0, 1'b1, 1'b1, 8'd0}},
            '{'{OP_TICK, 32'd100, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0}, 1'b1, SILENT_IDLE},
            '{'{OP_LOAD, 32'h8000_0000, 8'd0, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0},
              1'b1, SILENT_IDLE},
            '{'{OP_LOAD, 32'd0, 8'd255, 16'd1, 16'd0, 8'hFF, 8'hFF}, 1'b1, SILENT_IDLE},
            '{'{OP_LOAD, 32'd0, 8'd1, 16'd440, 16'd3, 8'd0, 8'd0}, 1'b1, SILENT_IDLE},
            '{'{OP_LOAD, 32'd0, 8'd2, 16'd0, 16'd1, 8'd0, 8'd0}, 1'b1, SILENT_IDLE},
            '{'{OP_PLAY, 32'hFFFF_FFF0, 8'd0, 16'd0, 16'd0, 8'd255, 8'hFF}, 1'b1,
              '{16'hFFFF, 8'hFF, 1'b1, 1'b1, 8'd0}},
            '{'{OP_TICK, 32'h0000_FFEE, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0}, 1'b1,
              '{16'hFFFF, 8'hFF, 1'b1, 1'b0, 8'd0}},
            '{'{OP_TICK, 32'h0000_FFEF, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0}, 1'b1,
              '{16'd440, 8'hFF, 1'b1, 1'b0, 8'd1}},
            '{'{OP_TICK, 32'h0000_FFF2, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0}, 1'b1,
              '{16'd0, 8'd0, 1'b1, 1'b0, 8'd2}},
            '{'{OP_LOAD, 32'd0, 8'd3, 16'd1234, 16'd2, 8'd0, 8'd0}, 1'b0, SILENT_IDLE},
            '{'{OP_TICK, 32'h0000_FFF3, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0}, 1'b0, SILENT_IDLE},
            '{'{OP_TICK, 32'h8000_FFF5, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0}, 1'b0, SILENT_IDLE},
            '{'{OP_PLAY, 32'd7, 8'd0, 16'd0, 16'd0, 8'd2, 8'd0}, 1'b0, SILENT_IDLE},
            '{'{OP_TICK, 32'h0001_0006, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0}, 1'b0, SILENT_IDLE},
            '{'{OP_TICK, 32'h0001_0009, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0}, 1'b0, SILENT_IDLE},
            '{'{OP_PLAY, 32'd0, 8'd0, 16'd0, 16'd0, 8'd3, 8'h55}, 1'b0, SILENT_IDLE},
            '{'{OP_STOP, 32'd0, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0}, 1'b1, SILENT_IDLE},
            '{'{OP_TICK, 32'hFFFF_FFFF, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0}, 1'b1, SILENT_IDLE}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].res);
        wait_drained();

        while (useful_items < ITEM_TARGET) begin
            if (useful_items >= TAIL_START)
                tail_quiet = 1'b1;
            if (!mid_drain_done && useful_items >= ITEM_TARGET / 2) begin
                mid_drain_done = 1'b1;
                wait_drained();
            end
            run_session();
        end

        idle_cycles(1);
        while (pending_tones.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_tones.size() != 0) begin
            $error("results still outstanding: %0d", pending_tones.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASS tone_pattern_sequencer");
        else
            $display("FAIL tone_pattern_sequencer");
        $finish;
    end

endmodule
